[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

[rtl/upe_pkg.sv]
package upe_pkg;

  // Field widths
  localparam int unsigned CpW      = 21;
  localparam int unsigned SelW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 4;

  localparam logic [CpW-1:0] MaxCodePoint = 21'h10FFFF;

  // Percent-encode set selector codes; codes above SetUserinfo act as userinfo
  localparam logic [SelW-1:0] SetC0       = 3'd0;
  localparam logic [SelW-1:0] SetFragment = 3'd1;
  localparam logic [SelW-1:0] SetQuery    = 3'd2;
  localparam logic [SelW-1:0] SetPath     = 3'd3;
  localparam logic [SelW-1:0] SetUserinfo = 3'd4;

  // Default depth of the queue between front and back
  localparam int unsigned FifoDepthDef = 4;

  // Characters
  localparam logic [ByteW-1:0] ChPercent   = 8'h25;
  localparam logic [ByteW-1:0] ChDigit0    = 8'h30;
  localparam logic [ByteW-1:0] ChUpperBase = 8'h37;  // 'A' minus ten
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;
  localparam logic [ByteW-1:0] ChTilde     = 8'h7E;

  // One classified code point: UTF-8 bytes, which of them get encoded
  typedef struct packed {
    logic                             bad;
    logic [1:0]                       last_idx;
    logic [MaxBytes-1:0]              enc;
    logic [MaxBytes-1:0][ByteW-1:0]   bytes;
  } upe_entry_t;

  // Membership of a byte in the selected percent-encode set
  function automatic logic in_set(input logic [ByteW-1:0] b, input logic [SelW-1:0] sel);
    logic c0;
    logic base;
    logic frag;
    logic query;
    logic path;
    logic user;
    c0    = (b < ChSpace) || (b > ChTilde);
    base  = c0 || (b == 8'h20) || (b == 8'h22) || (b == 8'h3C) || (b == 8'h3E);
    frag  = base || (b == 8'h60);
    query = base || (b == 8'h23);
    path  = query || (b == 8'h3F) || (b == 8'h60) || (b == 8'h7B) || (b == 8'h7D);
    user  = path || (b == 8'h2F) || (b == 8'h3A) || (b == 8'h3B) || (b == 8'h3D) ||
            (b == 8'h40) || (b == 8'h5B) || (b == 8'h5C) || (b == 8'h5D) ||
            (b == 8'h5E) || (b == 8'h7C);
    case (sel)
      SetC0:       return c0;
      SetFragment: return frag;
      SetQuery:    return query;
      SetPath:     return path;
      default:     return user;
    endcase
  endfunction

  // Uppercase hex digit for a nibble
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return ChDigit0 + {4'b0000, n};
    end else begin
      return ChUpperBase + {4'b0000, n};
    end
  endfunction

endpackage

[rtl/upe_if.sv]
// Code point channel
interface upe_in_if;
  logic                        valid;
  logic                        ready;
  logic [upe_pkg::CpW-1:0]     code_point;
  logic [upe_pkg::SelW-1:0]    encode_set;

  modport source (output valid, output code_point, output encode_set, input ready);
  modport sink   (input valid, input code_point, input encode_set, output ready);
endinterface

// Encoded byte channel
interface upe_out_if;
  logic                        valid;
  logic                        ready;
  logic [upe_pkg::ByteW-1:0]   out_byte;
  logic                        last_byte;
  logic                        bad_code_point;

  modport source (output valid, output out_byte, output last_byte, output bad_code_point,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input bad_code_point,
                  output ready);
endinterface

[rtl/upe_front.sv]
module upe_front (
  upe_in_if.sink              in_i,
  output logic                wr_valid_o,
  output upe_pkg::upe_entry_t wr_entry_o,
  input  logic                wr_ready_i
);

  logic [upe_pkg::CpW-1:0]  cp;
  logic [upe_pkg::SelW-1:0] sel;
  upe_pkg::upe_entry_t      entry;

  assign cp  = in_i.code_point;
  assign sel = in_i.encode_set;

  // Split the code point into UTF-8 bytes and mark the ones to encode
  always_comb begin
    entry          = '0;
    entry.bad      = (cp > upe_pkg::MaxCodePoint);
    if (cp < 21'h80) begin
      entry.bytes[0] = cp[7:0];
      entry.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      entry.bytes[0] = {3'b110, cp[10:6]};
      entry.bytes[1] = {2'b10, cp[5:0]};
      entry.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      entry.bytes[0] = {4'b1110, cp[15:12]};
      entry.bytes[1] = {2'b10, cp[11:6]};
      entry.bytes[2] = {2'b10, cp[5:0]};
      entry.last_idx = 2'd2;
    end else begin
      entry.bytes[0] = {5'b11110, cp[20:18]};
      entry.bytes[1] = {2'b10, cp[17:12]};
      entry.bytes[2] = {2'b10, cp[11:6]};
      entry.bytes[3] = {2'b10, cp[5:0]};
      entry.last_idx = 2'd3;
    end
    for (int i = 0; i < upe_pkg::MaxBytes; i++) begin
      entry.enc[i] = upe_pkg::in_set(entry.bytes[i], sel);
    end
  end

  // Push into the queue whenever it has room
  assign in_i.ready = wr_ready_i;
  assign wr_valid_o = in_i.valid;
  assign wr_entry_o = entry;

endmodule

[rtl/upe_fifo.sv]
module upe_fifo #(
  parameter int unsigned Depth = upe_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  upe_pkg::upe_entry_t wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output upe_pkg::upe_entry_t rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  upe_pkg::upe_entry_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign wr_ready_o = (count_q != Full);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/upe_back.sv]
module upe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_valid_i,
  output logic                rd_ready_o,
  input  upe_pkg::upe_entry_t rd_data_i,
  upe_out_if.source           out_o
);

  typedef enum logic [1:0] {
    PhMark,
    PhHi,
    PhLo
  } phase_e;

  upe_pkg::upe_entry_t         cur_q;
  logic                        cur_valid_q;
  logic [1:0]                  idx_q;
  phase_e                      ph_q;
  logic                        out_valid_q;
  logic [upe_pkg::ByteW-1:0]   out_byte_q;
  logic                        out_last_q;
  logic                        out_bad_q;

  logic                        load_out, step, cur_enc, byte_done, item_done, pop;
  logic [upe_pkg::ByteW-1:0]   cur_b, nxt_byte;

  assign load_out  = !out_valid_q || out_o.ready;
  assign step      = cur_valid_q && load_out;
  assign cur_enc   = cur_q.enc[idx_q];
  assign cur_b     = cur_q.bytes[idx_q];
  assign byte_done = cur_q.bad || !cur_enc || (ph_q == PhLo);
  assign item_done = byte_done && (cur_q.bad || (idx_q == cur_q.last_idx));
  assign rd_ready_o = !cur_valid_q || (step && item_done);
  assign pop       = rd_valid_i && rd_ready_o;

  // Pick the byte for the current position
  always_comb begin
    if (cur_q.bad) begin
      nxt_byte = '0;
    end else if (!cur_enc) begin
      nxt_byte = cur_b;
    end else begin
      case (ph_q)
        PhMark:  nxt_byte = upe_pkg::ChPercent;
        PhHi:    nxt_byte = upe_pkg::hex_char(cur_b[7:4]);
        default: nxt_byte = upe_pkg::hex_char(cur_b[3:0]);
      endcase
    end
  end

  // Walk bytes and phases, load the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      ph_q        <= PhMark;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      if (pop) begin
        cur_q       <= rd_data_i;
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
        ph_q        <= PhMark;
      end else if (step && item_done) begin
        cur_valid_q <= 1'b0;
      end else if (step) begin
        if (byte_done) begin
          idx_q <= idx_q + 1'b1;
          ph_q  <= PhMark;
        end else if (ph_q == PhMark) begin
          ph_q <= PhHi;
        end else begin
          ph_q <= PhLo;
        end
      end
      if (load_out) begin
        out_valid_q <= step;
      end
      if (step) begin
        out_byte_q <= nxt_byte;
        out_last_q <= item_done;
        out_bad_q  <= cur_q.bad;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.last_byte      = out_last_q;
  assign out_o.bad_code_point = out_bad_q;

endmodule

[rtl/url_percent_encoder_unit.sv]
// URL percent-encoder.
// in_i carries one beat per code point: code_point (21 bits) and encode_set
// (0 C0 control, 1 fragment, 2 query, 3 path, 4 to 7 userinfo).
// out_o carries one beat per output byte: out_byte, last_byte on the final
// beat of a code point, and bad_code_point on the single beat that stands
// for a code point above 0x10FFFF (out_byte 0, last_byte 1).
// A code point turns into 1 to 12 beats: each of its 1 to 4 UTF-8 bytes
// goes out as itself or as '%' plus two uppercase hex digits.
// An accepted code point goes through the queue, the back end's current
// entry register and the output register on its way to out_o. While out_o
// is ready, the back end sends one byte per cycle, so single-byte code
// points flow at one per cycle. The front end classifies a code point in
// the cycle it is taken and parks it in a FifoDepth entry queue, so input
// keeps flowing while the back end works through longer expansions.
// When out_o stalls, the output beat holds and the queue fills; in_i.ready
// drops once the queue is full.
// Reset empties the queue and clears the output register; no setup needed.
module url_percent_encoder_unit #(
  parameter int unsigned FifoDepth = upe_pkg::FifoDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upe_in_if.sink    in_i,
  upe_out_if.source out_o
);

  logic                wr_valid, wr_ready, rd_valid, rd_ready;
  upe_pkg::upe_entry_t wr_entry, rd_entry;

  // Classify incoming code points
  upe_front u_front (
    .in_i       (in_i),
    .wr_valid_o (wr_valid),
    .wr_entry_o (wr_entry),
    .wr_ready_i (wr_ready)
  );

  // Decouple front and back
  upe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_data_i  (wr_entry),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_data_o  (rd_entry)
  );

  // Emit bytes one per beat
  upe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_valid),
    .rd_ready_o (rd_ready),
    .rd_data_i  (rd_entry),
    .out_o      (out_o)
  );

endmodule

[rtl/upe_checker.sv]
`include "assert_macros.svh"

module upe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       last_byte_i,
  input logic       bad_code_point_i
);

  logic       stall;
  logic [9:0] payload;
  logic       bad_beat;
  logic       lit_beat;
  logic       out_of_range;

  assign stall        = out_valid_i && !out_ready_i;
  assign payload      = {out_byte_i, last_byte_i, bad_code_point_i};
  assign bad_beat     = out_valid_i && bad_code_point_i;
  assign lit_beat     = out_valid_i && !bad_code_point_i;
  assign out_of_range = (out_byte_i < upe_pkg::ChSpace) || (out_byte_i > upe_pkg::ChTilde);

  // Stalled beat stays up and holds its payload
  `ASSERT_CLK(a_out_hold_valid, clk_i, rst_ni, stall |=> out_valid_i)
  `ASSERT_CLK(a_out_hold_data, clk_i, rst_ni, stall |=> $stable(payload))

  // Error beat is a lone final beat with a zero byte
  `ASSERT_CLK(a_bad_alone, clk_i, rst_ni, bad_beat |-> (last_byte_i && (out_byte_i == 8'h00)))

  // Encoded output stays within printable ASCII
  `ASSERT_NEVER(a_printable, clk_i, rst_ni, lit_beat && out_of_range)

endmodule

bind url_percent_encoder_unit upe_checker u_upe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_byte_i       (out_o.out_byte),
  .last_byte_i      (out_o.last_byte),
  .bad_code_point_i (out_o.bad_code_point)
);

[tb/sv/url_percent_encoder_unit_test.sv]
`timescale 1ns / 1ps

module url_percent_encoder_unit_test;

  // One code point beat as the sender sees it
  typedef struct packed {
    logic [upe_pkg::CpW-1:0]  cp;
    logic [upe_pkg::SelW-1:0] sel;
  } cp_beat_t;

  // One encoded byte beat as the receiver should see it
  typedef struct packed {
    logic [upe_pkg::ByteW-1:0] ch;
    logic                      last;
    logic                      bad;
  } enc_beat_t;

  localparam int unsigned NumRandom = 236;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   recv_tick = 0;

  cp_beat_t  pending_cps[$];
  enc_beat_t expected_bytes[$];

  upe_in_if  cp_ch ();
  upe_out_if byte_ch ();

  url_percent_encoder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cp_ch.sink),
    .out_o  (byte_ch.source)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Is a UTF-8 byte escaped under the given set
  function automatic logic byte_escaped(input logic [upe_pkg::ByteW-1:0] b,
                                        input logic [upe_pkg::SelW-1:0]  sel);
    logic ctrl;
    logic shared;
    logic frag;
    logic qry;
    logic pth;
    logic usr;
    ctrl   = (b < 8'h20) || (b > 8'h7E);
    // space, double quote, less-than, greater-than
    shared = ctrl || (b inside {8'h20, 8'h22, 8'h3C, 8'h3E});
    frag   = shared || (b == 8'h60);                        // backtick
    qry    = shared || (b == 8'h23);                        // hash
    pth    = qry || (b inside {8'h3F, 8'h60, 8'h7B, 8'h7D});
    usr    = pth || (b inside {8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h40,
                               8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h7C});
    case (sel)
      upe_pkg::SetC0:       byte_escaped = ctrl;
      upe_pkg::SetFragment: byte_escaped = frag;
      upe_pkg::SetQuery:    byte_escaped = qry;
      upe_pkg::SetPath:     byte_escaped = pth;
      default:              byte_escaped = usr;
    endcase
  endfunction

  function automatic logic [upe_pkg::ByteW-1:0] hex_digit(input logic [3:0] nib);
    hex_digit = (nib < 4'd10) ? (8'h30 + {4'b0000, nib})
                              : (8'h41 + {4'b0000, nib} - 8'd10);
  endfunction

  // Expand one code point into the byte beats it should produce
  function automatic void predict_encoding(input logic [upe_pkg::CpW-1:0]  cp,
                                           input logic [upe_pkg::SelW-1:0] sel);
    logic [upe_pkg::ByteW-1:0] utf8[$];
    logic [upe_pkg::ByteW-1:0] chars[$];
    enc_beat_t                 beat;
    if (cp > upe_pkg::MaxCodePoint) begin
      beat = '{ch: '0, last: 1'b1, bad: 1'b1};
      expected_bytes.push_back(beat);
      return;
    end
    if (cp < 21'h80) begin
      utf8.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      utf8.push_back({3'b110, cp[10:6]});
      utf8.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      utf8.push_back({4'b1110, cp[15:12]});
      utf8.push_back({2'b10, cp[11:6]});
      utf8.push_back({2'b10, cp[5:0]});
    end else begin
      utf8.push_back({5'b11110, cp[20:18]});
      utf8.push_back({2'b10, cp[17:12]});
      utf8.push_back({2'b10, cp[11:6]});
      utf8.push_back({2'b10, cp[5:0]});
    end
    foreach (utf8[i]) begin
      if (byte_escaped(utf8[i], sel)) begin
        chars.push_back(upe_pkg::ChPercent);
        chars.push_back(hex_digit(utf8[i][7:4]));
        chars.push_back(hex_digit(utf8[i][3:0]));
      end else begin
        chars.push_back(utf8[i]);
      end
    end
    foreach (chars[i]) begin
      beat = '{ch: chars[i], last: (i == chars.size() - 1), bad: 1'b0};
      expected_bytes.push_back(beat);
    end
  endfunction

  task automatic add_cp(input logic [upe_pkg::CpW-1:0] cp, input logic [upe_pkg::SelW-1:0] sel);
    cp_beat_t b;
    b = '{cp: cp, sel: sel};
    pending_cps.push_back(b);
  endtask

  // Driver: predict on each accepted beat, send in bursts with random gaps
  always @(posedge clk or negedge rst_n) begin
    cp_beat_t nxt;
    if (!rst_n) begin
      cp_ch.valid      <= 1'b0;
      cp_ch.code_point <= '0;
      cp_ch.encode_set <= '0;
      gap_left   = 0;
      burst_left = 0;
    end else if (!cp_ch.valid || cp_ch.ready) begin
      if (cp_ch.valid) begin
        predict_encoding(cp_ch.code_point, cp_ch.encode_set);
      end
      if (gap_left > 0) begin
        gap_left--;
        cp_ch.valid <= 1'b0;
      end else if (pending_cps.size() > 0) begin
        nxt = pending_cps.pop_front();
        cp_ch.valid      <= 1'b1;
        cp_ch.code_point <= nxt.cp;
        cp_ch.encode_set <= nxt.sel;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        cp_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted byte beat, stall on a shifting pattern
  always @(posedge clk or negedge rst_n) begin
    enc_beat_t want;
    if (!rst_n) begin
      byte_ch.ready <= 1'b0;
      recv_tick = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte beat: out_byte %h last %b bad %b",
                 byte_ch.out_byte, byte_ch.last_byte, byte_ch.bad_code_point);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (byte_ch.out_byte !== want.ch) begin
            $error("out_byte mismatch: expected %h, actual %h", want.ch, byte_ch.out_byte);
            fail_count++;
          end
          if (byte_ch.last_byte !== want.last) begin
            $error("last_byte mismatch: expected %b, actual %b", want.last, byte_ch.last_byte);
            fail_count++;
          end
          if (byte_ch.bad_code_point !== want.bad) begin
            $error("bad_code_point mismatch: expected %b, actual %b",
                   want.bad, byte_ch.bad_code_point);
            fail_count++;
          end
        end
      end
      recv_tick++;
      case ((recv_tick / 97) % 4)
        0:       byte_ch.ready <= 1'b1;
        1:       byte_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       byte_ch.ready <= ($urandom_range(0, 1) != 0);
        default: byte_ch.ready <= ((recv_tick % 7) < 3);
      endcase
    end
  end

  // Stimulus and end of run
  initial begin
    logic [7:0]                punct[] = '{8'h20, 8'h22, 8'h23, 8'h3C, 8'h3E, 8'h60, 8'h3F,
                                           8'h7B, 8'h7D, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h40,
                                           8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h7C, 8'h7E, 8'h7F,
                                           8'h1F, 8'h25, 8'h41};
    logic [upe_pkg::CpW-1:0]   cp;
    logic [upe_pkg::SelW-1:0]  sel;
    int                        pick;
    rst_n <= 1'b0;

    // Directed: range edges, every set, surrogates, out-of-range code points
    add_cp(21'h000000, upe_pkg::SetC0);
    add_cp(21'h00001F, upe_pkg::SetC0);
    add_cp(21'h000020, upe_pkg::SetC0);
    add_cp(21'h000020, upe_pkg::SetFragment);
    add_cp(21'h000060, upe_pkg::SetFragment);
    add_cp(21'h000060, upe_pkg::SetQuery);
    add_cp(21'h000023, upe_pkg::SetQuery);
    add_cp(21'h000023, upe_pkg::SetFragment);
    add_cp(21'h00003F, upe_pkg::SetPath);
    add_cp(21'h00007D, upe_pkg::SetPath);
    add_cp(21'h000040, upe_pkg::SetUserinfo);
    add_cp(21'h00005C, 3'd5);
    add_cp(21'h00007C, 3'd7);
    add_cp(21'h00007E, upe_pkg::SetUserinfo);
    add_cp(21'h00007F, upe_pkg::SetC0);
    add_cp(21'h000080, upe_pkg::SetFragment);
    add_cp(21'h0007FF, upe_pkg::SetQuery);
    add_cp(21'h000800, upe_pkg::SetPath);
    add_cp(21'h00D800, upe_pkg::SetC0);
    add_cp(21'h00DFFF, 3'd6);
    add_cp(21'h00FFFF, upe_pkg::SetUserinfo);
    add_cp(21'h010000, upe_pkg::SetC0);
    add_cp(21'h10FFFF, 3'd7);
    add_cp(21'h110000, upe_pkg::SetPath);
    add_cp(21'h1FFFFF, 3'd7);

    // Random: punctuation and other ASCII against the sets, mixed with wider code points
    for (int n = 0; n < NumRandom; n++) begin
      sel  = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        cp = 21'(punct[$urandom_range(0, punct.size() - 1)]);
      end else if (pick < 45) begin
        cp = 21'($urandom_range(0, 8'h7F));
      end else if (pick < 60) begin
        cp = 21'($urandom_range(21'h80, 21'h7FF));
      end else if (pick < 72) begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
      end else if (pick < 77) begin
        cp = 21'($urandom_range(21'hD800, 21'hDFFF));
      end else if (pick < 88) begin
        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      end else if (pick < 95) begin
        cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
      end else begin
        cp = 21'($urandom());
      end
      add_cp(cp, sel);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain the sender, then the expected bytes, then let the pipe settle
    while (pending_cps.size() != 0 || cp_ch.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
